/* hdl/fhc_pkg.sv */
// Shared constants, types and tables for the fuzzy heating controller.
// Holds the membership breakpoints, the rule table and the class weights.
// No dependencies.
package fhc_pkg;

    // Fixed-point formats.
    localparam int INPUT_FRAC_BITS = 8;
    localparam int DEGREE_BITS     = 16;
    localparam int DFRAC           = DEGREE_BITS - 1;
    localparam int SCALE_SHIFT     = DFRAC - INPUT_FRAC_BITS;

    // Port field widths.
    localparam int TEMP_W = 16;
    localparam int HUM_W  = 15;
    localparam int CORR_W = 14;

    // Sizes of the fuzzy system.
    localparam int NUM_SETS    = 5;
    localparam int NUM_CLASSES = 7;
    localparam int NUM_RULES   = NUM_SETS * NUM_SETS;

    // Datapath widths.
    localparam int X_W        = TEMP_W + 2;
    localparam int DIST_W     = 12;
    localparam int SPAN_W     = 4;
    localparam int RECIP_K    = 20;
    localparam int RECIP_W    = RECIP_K;
    localparam int RPROD_W    = DIST_W + RECIP_W;
    localparam int DEG_W      = DEGREE_BITS;
    localparam int SQ_W       = 2 * DEGREE_BITS - 1;
    localparam int SUM_W      = SQ_W + 4;
    localparam int STR_W      = (SUM_W + 1) / 2;
    localparam int SQRT_STEPS = STR_W;
    localparam int W_W        = 28;
    localparam int PROD_W     = 48;
    localparam int NUM_W      = 51;
    localparam int DEN_W      = 21;
    localparam int DEN100_W   = DEN_W + 7;
    localparam int DIV_W      = DEN100_W + SCALE_SHIFT;
    localparam int Q_BITS     = 13;
    localparam int CORR_MAX   = 1 << (Q_BITS - 1);

    // Membership shape codes.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_FALL = 2'd0;
    localparam kind_t KIND_TRI  = 2'd1;
    localparam kind_t KIND_RISE = 2'd2;

    // Temperature sets: very low, low, normal, high, very high (whole degrees).
    localparam kind_t T_KIND [NUM_SETS] = '{KIND_FALL, KIND_TRI, KIND_TRI, KIND_TRI, KIND_RISE};
    localparam int    T_P0   [NUM_SETS] = '{10, 10, 18, 20, 25};
    localparam int    T_P1   [NUM_SETS] = '{15, 16, 20, 25, 30};
    localparam int    T_P2   [NUM_SETS] = '{0, 20, 22, 30, 0};

    // Humidity sets (whole percent).
    localparam kind_t H_KIND [NUM_SETS] = '{KIND_FALL, KIND_TRI, KIND_TRI, KIND_TRI, KIND_RISE};
    localparam int    H_P0   [NUM_SETS] = '{10, 10, 30, 40, 60};
    localparam int    H_P1   [NUM_SETS] = '{20, 25, 40, 55, 70};
    localparam int    H_P2   [NUM_SETS] = '{0, 40, 50, 70, 0};

    // Rule table: [temperature set][humidity set] gives the output class.
    typedef logic [2:0] class_t;
    localparam class_t RULE_CLASS [NUM_SETS][NUM_SETS] = '{
        '{3'd5, 3'd5, 3'd6, 3'd6, 3'd6},
        '{3'd3, 3'd3, 3'd4, 3'd4, 3'd5},
        '{3'd3, 3'd3, 3'd3, 3'd3, 3'd2},
        '{3'd3, 3'd3, 3'd2, 3'd2, 3'd1},
        '{3'd2, 3'd1, 3'd1, 3'd0, 3'd0}
    };

    // Class weights in hundredths.
    localparam int W_BASE [NUM_CLASSES] = '{0, -840, -410, -70, 70, 420, 830};
    localparam int W_ALT  [NUM_CLASSES] = '{0, 340, 159, 70, 180, 80, 169};
    localparam int W_MUL  [NUM_CLASSES] = '{0, 100, 285, 100, 100, 285, 100};
    localparam int W0_MUL      = -1500;
    localparam int W0_ONE_TERM = -1000;

    // Quotient and flags handed from the defuzzifier to the output stage.
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic              sat;
        logic              zero;
        logic [Q_BITS-1:0] quot;
    } quot_t;

endpackage

/* hdl/fhc_member.sv */
// One membership function: ramp or triangle with fixed breakpoints.
// Two register stages: reciprocal multiply, then quotient correction.
// Depends on fhc_pkg.
module fhc_member #(
    parameter fhc_pkg::kind_t KIND = fhc_pkg::KIND_TRI,
    parameter int             P0   = 0,
    parameter int             P1   = 1,
    parameter int             P2   = 2
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [fhc_pkg::X_W-1:0]     x,
    output logic        [fhc_pkg::DEG_W-1:0]   degree
);
    import fhc_pkg::*;

    localparam logic signed [X_W-1:0] BP_A = X_W'(P0 * (1 << INPUT_FRAC_BITS));
    localparam logic signed [X_W-1:0] BP_B = X_W'(P1 * (1 << INPUT_FRAC_BITS));
    localparam logic signed [X_W-1:0] BP_C = X_W'(P2 * (1 << INPUT_FRAC_BITS));
    localparam logic signed [X_W-1:0] DN_END = (KIND == KIND_TRI) ? BP_C : BP_B;
    localparam int UP_SPAN = P1 - P0;
    localparam int DN_SPAN = (KIND == KIND_TRI) ? (P2 - P1) : (P1 - P0);
    localparam logic [RECIP_W-1:0] UP_M = RECIP_W'((1 << RECIP_K) / UP_SPAN);
    localparam logic [RECIP_W-1:0] DN_M = RECIP_W'((1 << RECIP_K) / DN_SPAN);
    localparam logic [DEG_W-1:0] ONE_DEG = DEG_W'(1 << DFRAC);
    localparam int SC_W = DIST_W + SCALE_SHIFT;

    logic signed [X_W-1:0]   diff;
    logic                    fixed_next, fixed_reg;
    logic [DEG_W-1:0]        fixval_next, fixval_reg;
    logic                    dn_next, dn_reg;
    logic [DIST_W-1:0]       dist_next, dist_reg;
    logic [RPROD_W-1:0]      prod_next, prod_reg;
    logic [DEG_W-1:0]        q0, quot;
    logic [SPAN_W-1:0]       span;
    logic [SC_W-1:0]         scaled, rem;
    logic [DEG_W-1:0]        degree_next, degree_reg;

    // Region select and distance from the active breakpoint.
    always_comb begin
        fixed_next  = 1'b1;
        fixval_next = '0;
        dn_next     = 1'b0;
        diff        = '0;
        unique case (KIND)
            KIND_FALL: begin
                if (x <= BP_A) begin
                    fixval_next = ONE_DEG;
                end else if (x < BP_B) begin
                    fixed_next = 1'b0;
                    dn_next    = 1'b1;
                    diff       = DN_END - x;
                end
            end
            KIND_RISE: begin
                if (x >= BP_B) begin
                    fixval_next = ONE_DEG;
                end else if (x > BP_A) begin
                    fixed_next = 1'b0;
                    diff       = x - BP_A;
                end
            end
            default: begin
                if (x > BP_A && x <= BP_B) begin
                    fixed_next = 1'b0;
                    diff       = x - BP_A;
                end else if (x > BP_B && x <= BP_C) begin
                    fixed_next = 1'b0;
                    dn_next    = 1'b1;
                    diff       = DN_END - x;
                end
            end
        endcase
        dist_next = diff[DIST_W-1:0];
        prod_next = RPROD_W'(dist_next) * RPROD_W'(dn_next ? DN_M : UP_M);
    end

    // First stage: estimate of distance over span.
    always_ff @(posedge aclk) begin
        if (en) begin
            fixed_reg  <= fixed_next;
            fixval_reg <= fixval_next;
            dn_reg     <= dn_next;
            dist_reg   <= dist_next;
            prod_reg   <= prod_next;
        end
    end

    // The estimate is low by at most one; one compare fixes it.
    always_comb begin
        q0     = prod_reg[RECIP_K-SCALE_SHIFT +: DEG_W];
        span   = dn_reg ? SPAN_W'(DN_SPAN) : SPAN_W'(UP_SPAN);
        scaled = {dist_reg, {SCALE_SHIFT{1'b0}}};
        rem    = scaled - SC_W'(q0) * SC_W'(span);
        quot   = (rem >= SC_W'(span)) ? q0 + DEG_W'(1) : q0;
        degree_next = fixed_reg ? fixval_reg : quot;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            degree_reg <= degree_next;
        end
    end

    assign degree = degree_reg;

endmodule

/* hdl/fhc_fuzzify.sv */
// Fuzzification of both inputs and min-AND firing of all 25 rules.
// Three register stages; the last holds the squared rule strengths.
// Depends on fhc_pkg and fhc_member.
module fhc_fuzzify (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [fhc_pkg::TEMP_W-1:0]   temperature,
    input  logic        [fhc_pkg::HUM_W-1:0]    humidity,
    output logic                                out_valid,
    output logic        [fhc_pkg::SQ_W-1:0]     sq [fhc_pkg::NUM_RULES]
);
    import fhc_pkg::*;

    logic signed [X_W-1:0] t_x, h_x;
    logic [DEG_W-1:0]      t_deg [NUM_SETS];
    logic [DEG_W-1:0]      h_deg [NUM_SETS];
    logic [2:0]            valid_reg;
    logic [SQ_W-1:0]       sq_next [NUM_RULES];
    logic [SQ_W-1:0]       sq_reg  [NUM_RULES];
    logic [DEG_W-1:0]      fire;

    assign t_x = {{(X_W-TEMP_W){temperature[TEMP_W-1]}}, temperature};
    assign h_x = {{(X_W-HUM_W){1'b0}}, humidity};

    // Membership units for both inputs.
    for (genvar g = 0; g < NUM_SETS; g++) begin : g_sets
        fhc_member #(
            .KIND(T_KIND[g]), .P0(T_P0[g]), .P1(T_P1[g]), .P2(T_P2[g])
        ) u_temp (
            .aclk(aclk), .en(en), .x(t_x), .degree(t_deg[g])
        );
        fhc_member #(
            .KIND(H_KIND[g]), .P0(H_P0[g]), .P1(H_P1[g]), .P2(H_P2[g])
        ) u_hum (
            .aclk(aclk), .en(en), .x(h_x), .degree(h_deg[g])
        );
    end

    // Rule strength is the smaller degree; square it for the class sums.
    always_comb begin
        fire = '0;
        for (int i = 0; i < NUM_SETS; i++) begin
            for (int j = 0; j < NUM_SETS; j++) begin
                fire = (t_deg[i] < h_deg[j]) ? t_deg[i] : h_deg[j];
                sq_next[i*NUM_SETS+j] = SQ_W'(fire) * SQ_W'(fire);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    // Valid bits follow the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    assign out_valid = valid_reg[2];
    assign sq        = sq_reg;

endmodule

/* hdl/fhc_aggregate.sv */
// Class aggregation: sum of squared strengths per class, then a pipelined
// integer square root, one result bit per stage. Depends on fhc_pkg.
module fhc_aggregate (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [fhc_pkg::SQ_W-1:0]         sq [fhc_pkg::NUM_RULES],
    output logic                             out_valid,
    output logic [fhc_pkg::STR_W-1:0]        strength [fhc_pkg::NUM_CLASSES]
);
    import fhc_pkg::*;

    localparam int RW = SUM_W + 1;

    logic [SUM_W-1:0]      sum_next [NUM_CLASSES];
    logic [SUM_W-1:0]      sum_reg  [NUM_CLASSES];
    logic                  sum_valid_reg;
    logic [RW-1:0]         rem_reg [SQRT_STEPS][NUM_CLASSES];
    logic [RW-1:0]         res_reg [SQRT_STEPS][NUM_CLASSES];
    logic [SQRT_STEPS-1:0] sv_reg;

    // Per-class sum over the rules that map to that class.
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            sum_next[c] = '0;
            for (int r = 0; r < NUM_RULES; r++) begin
                if (RULE_CLASS[r / NUM_SETS][r % NUM_SETS] == class_t'(c)) begin
                    sum_next[c] = sum_next[c] + SUM_W'(sq[r]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            sv_reg        <= '0;
        end else if (en) begin
            sum_valid_reg <= in_valid;
            sv_reg        <= {sv_reg[SQRT_STEPS-2:0], sum_valid_reg};
        end
    end

    // Square root stages, the test bit falling by two places each stage.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [RW-1:0] rem_in  [NUM_CLASSES];
        logic [RW-1:0] res_in  [NUM_CLASSES];
        logic [RW-1:0] rem_nx  [NUM_CLASSES];
        logic [RW-1:0] res_nx  [NUM_CLASSES];

        always_comb begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (k == 0) begin
                    rem_in[c] = RW'(sum_reg[c]);
                    res_in[c] = '0;
                end else begin
                    rem_in[c] = rem_reg[(k == 0) ? 0 : k-1][c];
                    res_in[c] = res_reg[(k == 0) ? 0 : k-1][c];
                end
                if (rem_in[c] >= res_in[c] + BIT) begin
                    rem_nx[c] = rem_in[c] - (res_in[c] + BIT);
                    res_nx[c] = (res_in[c] >> 1) + BIT;
                end else begin
                    rem_nx[c] = rem_in[c];
                    res_nx[c] = res_in[c] >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_nx;
                res_reg[k] <= res_nx;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            strength[c] = res_reg[SQRT_STEPS-1][c][STR_W-1:0];
        end
    end

    assign out_valid = sv_reg[SQRT_STEPS-1];

endmodule

/* hdl/fhc_defuzz.sv */
// Weighted-average defuzzification: class weights, products, sums and a
// pipelined restoring divider with a saturation test. Depends on fhc_pkg.
module fhc_defuzz (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [fhc_pkg::STR_W-1:0]     strength [fhc_pkg::NUM_CLASSES],
    output fhc_pkg::quot_t                result
);
    import fhc_pkg::*;

    localparam longint ONE_L = longint'(1) << DFRAC;
    localparam logic signed [STR_W:0] NEG_ONE = -(STR_W+1)'(ONE_L);
    localparam logic signed [W_W-1:0] W0 = W_W'(longint'(W0_MUL) * ONE_L);
    localparam logic signed [PROD_W-1:0] TERM0_ONE =
        PROD_W'(longint'(W0_ONE_TERM) * ONE_L * ONE_L);

    // Stage 1: weights.
    logic signed [STR_W:0]   d;
    logic signed [W_W-1:0]   w_next [NUM_CLASSES];
    logic signed [W_W-1:0]   w_reg  [NUM_CLASSES];
    logic [STR_W-1:0]        s1_reg [NUM_CLASSES];
    logic [DEN_W-1:0]        den_next, den1_reg, den2_reg;
    logic                    s0one_reg;
    // Stage 2: products.
    logic signed [PROD_W-1:0] p_next [NUM_CLASSES];
    logic signed [PROD_W-1:0] p_reg  [NUM_CLASSES];
    // Stage 3: sums.
    logic signed [NUM_W-1:0] num_next, num_reg;
    logic [DEN100_W-1:0]     den100_reg;
    logic                    zero3_reg;
    // Stage 4: magnitude and rounding offset.
    logic [DIV_W-1:0]        div_next, div4_reg, div5_reg;
    logic [NUM_W-1:0]        mag;
    logic [NUM_W-1:0]        x4_reg, x5_reg;
    logic                    neg4_reg, zero4_reg, neg5_reg, zero5_reg, sat5_reg;
    // Divider stages.
    logic [NUM_W-1:0]        rem_reg  [Q_BITS];
    logic [Q_BITS-1:0]       q_reg    [Q_BITS];
    logic [DIV_W-1:0]        dv_reg   [Q_BITS];
    logic [Q_BITS-1:0]       neg_reg, sat_reg, zero_reg;
    logic [4+Q_BITS:0]       valid_reg;

    // Class weight from the strength difference with the previous class.
    always_comb begin
        d        = '0;
        den_next = '0;
        w_next[0] = W0;
        for (int i = 1; i < NUM_CLASSES; i++) begin
            d = $signed({1'b0, strength[i-1]}) - $signed({1'b0, strength[i]});
            if (d == NEG_ONE) begin
                w_next[i] = W_W'(longint'(W_BASE[i] + W_ALT[i]) * ONE_L);
            end else begin
                w_next[i] = W_W'(longint'(W_BASE[i]) * ONE_L)
                          + W_W'(longint'(W_MUL[i]) * longint'(d));
            end
        end
        for (int i = 0; i < NUM_CLASSES; i++) begin
            den_next = den_next + DEN_W'(strength[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg     <= w_next;
            s1_reg    <= strength;
            den1_reg  <= den_next;
            s0one_reg <= (STR_W+1)'(strength[0]) == (STR_W+1)'(ONE_L);
        end
    end

    // Strength times weight; a full first class takes its fixed term.
    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            p_next[i] = PROD_W'($signed({1'b0, s1_reg[i]})) * PROD_W'(w_reg[i]);
        end
        if (s0one_reg) begin
            p_next[0] = TERM0_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= p_next;
            den2_reg <= den1_reg;
        end
    end

    // Numerator sum and scaled denominator.
    always_comb begin
        num_next = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            num_next = num_next + NUM_W'(p_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= num_next;
            den100_reg <= DEN100_W'(den2_reg * DEN100_W'(100));
            zero3_reg  <= (den2_reg == '0);
        end
    end

    // Magnitude plus half the divisor, for rounding halves away from zero.
    always_comb begin
        mag      = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        div_next = {den100_reg, {SCALE_SHIFT{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x4_reg    <= mag + NUM_W'(div_next >> 1);
            div4_reg  <= div_next;
            neg4_reg  <= num_reg[NUM_W-1];
            zero4_reg <= zero3_reg;
        end
    end

    // Saturation when the quotient would pass the field limit.
    always_ff @(posedge aclk) begin
        if (en) begin
            x5_reg    <= x4_reg;
            div5_reg  <= div4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            sat5_reg  <= x4_reg >= ((NUM_W'(div4_reg) << (Q_BITS - 1)) + NUM_W'(div4_reg));
        end
    end

    // Restoring division, one quotient bit per stage from the top.
    for (genvar k = 0; k < Q_BITS; k++) begin : g_div
        localparam int SH = Q_BITS - 1 - k;
        logic [NUM_W-1:0]  rem_in, rem_nx, trial;
        logic [Q_BITS-1:0] q_in, q_nx;
        logic [DIV_W-1:0]  dv_in;
        logic              neg_in, sat_in, zero_in;

        always_comb begin
            if (k == 0) begin
                rem_in  = x5_reg;
                q_in    = '0;
                dv_in   = div5_reg;
                neg_in  = neg5_reg;
                sat_in  = sat5_reg;
                zero_in = zero5_reg;
            end else begin
                rem_in  = rem_reg[(k == 0) ? 0 : k-1];
                q_in    = q_reg[(k == 0) ? 0 : k-1];
                dv_in   = dv_reg[(k == 0) ? 0 : k-1];
                neg_in  = neg_reg[(k == 0) ? 0 : k-1];
                sat_in  = sat_reg[(k == 0) ? 0 : k-1];
                zero_in = zero_reg[(k == 0) ? 0 : k-1];
            end
            trial = NUM_W'(dv_in) << SH;
            q_nx  = q_in;
            if (rem_in >= trial) begin
                rem_nx   = rem_in - trial;
                q_nx[SH] = 1'b1;
            end else begin
                rem_nx = rem_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_nx;
                q_reg[k]    <= q_nx;
                dv_reg[k]   <= dv_in;
                neg_reg[k]  <= neg_in;
                sat_reg[k]  <= sat_in;
                zero_reg[k] <= zero_in;
            end
        end
    end

    // Valid bits for the five front stages and the divider.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3+Q_BITS:0], in_valid};
        end
    end

    always_comb begin
        result.valid = valid_reg[4+Q_BITS];
        result.neg   = neg_reg[Q_BITS-1];
        result.sat   = sat_reg[Q_BITS-1];
        result.zero  = zero_reg[Q_BITS-1];
        result.quot  = q_reg[Q_BITS-1];
    end

endmodule

/* hdl/fuzzy_heating_controller_top.sv */
// Top level of the fuzzy heating controller: stream ports, pipeline enable
// and output register. Depends on fhc_pkg, fhc_fuzzify, fhc_aggregate, fhc_defuzz.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------
//  s_       | in        | temperature, humidity (one sample pair)
//  m_       | out       | correction, raise_heat, no_rule_fired
//
// One sample pair enters per cycle while no result waits on m_tready.
// The longest parts of the pipeline are the 18-stage square root and the 13-stage divider.
// Reset (aresetn low, synchronous) clears every valid bit and the output.
// When a result waits on m_tready the whole pipeline holds; nothing is
// dropped or repeated, and the input is taken again once the result leaves.
module fuzzy_heating_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] temperature, [30:16] humidity, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [13:0] correction, [14] raise_heat, [15] no_rule_fired
);
    import fhc_pkg::*;

    logic                     en;
    logic                     fz_valid, ag_valid;
    logic [SQ_W-1:0]          sq [NUM_RULES];
    logic [STR_W-1:0]         strength [NUM_CLASSES];
    quot_t                    res;
    logic [Q_BITS-1:0]        corr_mag;
    logic [CORR_W-1:0]        corr_next;
    logic                     raise_next, none_next;
    logic                     m_tvalid_reg;
    logic [15:0]              m_tdata_reg;

    // The pipeline moves whenever the output register is free or being taken.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    fhc_fuzzify u_fuzzify (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid),
        .temperature(s_tdata[TEMP_W-1:0]),
        .humidity(s_tdata[TEMP_W +: HUM_W]),
        .out_valid(fz_valid), .sq(sq)
    );

    fhc_aggregate u_aggregate (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(fz_valid), .sq(sq),
        .out_valid(ag_valid), .strength(strength)
    );

    fhc_defuzz u_defuzz (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(ag_valid), .strength(strength),
        .result(res)
    );

    // Saturate, apply the sign and handle the case of no rule firing.
    always_comb begin
        corr_mag  = res.sat ? Q_BITS'(CORR_MAX) : res.quot;
        corr_next = res.neg ? CORR_W'(-CORR_W'(corr_mag)) : CORR_W'(corr_mag);
        raise_next = !(res.neg && corr_mag != '0);
        none_next  = 1'b0;
        if (res.zero) begin
            corr_next  = '0;
            raise_next = 1'b1;
            none_next  = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else if (en) begin
            m_tvalid_reg <= res.valid;
            m_tdata_reg  <= {none_next, raise_next, corr_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // No rule fired means a zero correction with the raise flag set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> m_tdata[13:0] == '0 && m_tdata[14])
        else $error("no_rule_fired without zero correction");

    // The raise flag agrees with the sign of the correction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14] == !m_tdata[13])
        else $error("raise_heat disagrees with the sign of correction");

    // The correction stays within the saturation limits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[13:0]) <= $signed(14'sd4096)
                  && $signed(m_tdata[13:0]) >= $signed(-14'sd4096))
        else $error("correction beyond its saturation limits");

    // A held result keeps the pipeline frozen and the input closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input open while a result is held");

endmodule
